### hw/rtl/sfl_pkg.sv
// shared types and constants of the size sorted free list
package sfl_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int OFF_W = 48;
	localparam int SIZE_W = 32;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int ENTRY_COUNT_W = 7;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [OFF_W-1:0] offset;
		logic signed [SIZE_W-1:0] size;
	} entry_t;

	// command from controller to datapath, valid in the accept cycle
	typedef struct packed {
		logic load;
		logic sorted;
		logic pop;
		logic [CNT_W-1:0] count;
	} cmd_t;

endpackage

### hw/rtl/sfl_ctrl.sv
// controller of the size sorted free list: handshake, count and status
module sfl_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [sfl_pkg::KIND_W-1:0] kind,
	output logic out_valid,
	input logic out_stall,
	output sfl_pkg::cmd_t cmd,
	output logic [sfl_pkg::CNT_W-1:0] count,
	output logic [sfl_pkg::STAT_W-1:0] status
);
	import sfl_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [STAT_W-1:0] status_q;
	logic [STAT_W-1:0] status_d;
	logic accept;
	logic full;
	logic empty;

	assign out_valid = (state_q == ST_HOLD);
	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;
	assign full = (count_q >= CNT_W'(LIST_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.load = 1'b0;
		cmd.sorted = 1'b0;
		cmd.pop = 1'b0;
		cmd.count = count_q;
		count_d = count_q;
		status_d = status_q;
		state_d = state_q;
		case (state_q)
			ST_IDLE: state_d = ST_IDLE;
			ST_HOLD: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (accept) begin
			state_d = ST_HOLD;
			status_d = STAT_OK;
			case (kind)
				KIND_INSERT, KIND_APPEND: begin
					if (full) begin
						status_d = STAT_FULL;
					end else begin
						cmd.load = 1'b1;
						cmd.sorted = (kind == KIND_INSERT);
						count_d = count_q + CNT_W'(1);
					end
				end
				KIND_POP: begin
					if (empty) begin
						status_d = STAT_EMPTY;
					end else begin
						cmd.pop = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
				end
				default: status_d = STAT_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			status_q <= STAT_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			status_q <= status_d;
		end
	end

	assign count = count_q;
	assign status = status_q;

endmodule

### hw/rtl/sfl_datapath.sv
// datapath of the size sorted free list: the sorted shift chain of slots
module sfl_datapath (
	input logic clk,
	input sfl_pkg::cmd_t cmd,
	input logic signed [sfl_pkg::OFF_W-1:0] entry_offset,
	input logic signed [sfl_pkg::SIZE_W-1:0] entry_size,
	output sfl_pkg::entry_t head
);
	import sfl_pkg::*;

	entry_t slot_q [LIST_DEPTH];
	entry_t new_entry;
	logic [LIST_DEPTH-1:0] hit;
	logic [LIST_DEPTH-1:0] pre;
	logic [LIST_DEPTH-1:0] taken_above;

	assign new_entry.offset = entry_offset;
	assign new_entry.size = entry_size;

	// each slot compares at once; the first free slot, at the count, always hits
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			hit[i] = (cmd.sorted && (CNT_W'(i) < cmd.count)
				&& ($signed(slot_q[i].size) <= $signed(entry_size)))
				|| (CNT_W'(i) == cmd.count);
		end
	end

	// log-depth prefix or: some earlier slot already took the entry
	always_comb begin
		pre = hit;
		for (int k = 1; k < LIST_DEPTH; k = k * 2) begin
			pre = pre | (pre << k);
		end
		taken_above = pre << 1;
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_slot
		entry_t from_up;
		entry_t from_down;
		if (i == 0) begin : g_first
			assign from_up = slot_q[i];
		end else begin : g_mid
			assign from_up = slot_q[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign from_down = slot_q[i];
		end else begin : g_rest
			assign from_down = slot_q[i+1];
		end
		always_ff @(posedge clk) begin
			if (cmd.load) begin
				if (taken_above[i]) begin
					slot_q[i] <= from_up;
				end else if (hit[i]) begin
					slot_q[i] <= new_entry;
				end
			end else if (cmd.pop) begin
				slot_q[i] <= from_down;
			end
		end
	end

	assign head = slot_q[0];

endmodule

### hw/rtl/size_sorted_free_list_unit.sv
// top level of the size sorted free list for worst-fit block reuse
// usage:
//   input channel in_valid/in_stall carries kind, entry_offset, entry_size;
//   kind selects sorted insert by size, append at tail, or pop of the head
//   output channel out_valid/out_stall returns one item per input item:
//   head entry after the step, entry count, empty flag and status
//   latency: the result is shown the cycle after the item is accepted
//   throughput: one item per cycle unless a result waits under out_stall;
//   the chain compares all slots in parallel and shifts in the same cycle
//   while a result waits under out_stall, in_stall is raised and the list,
//   count and result hold; the next item is taken in the cycle the result
//   leaves
//   reset clears the count and result valid; slot contents are not cleared,
//   only slots below the count are ever shown
//   head fields read as zero while the list is empty
//   full list: insert or append is dropped with status full
//   empty list: pop leaves the list alone with status empty
module size_sorted_free_list_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [sfl_pkg::KIND_W-1:0] kind,
	input logic signed [sfl_pkg::OFF_W-1:0] entry_offset,
	input logic signed [sfl_pkg::SIZE_W-1:0] entry_size,
	output logic out_valid,
	input logic out_stall,
	output logic signed [sfl_pkg::OFF_W-1:0] head_offset,
	output logic signed [sfl_pkg::SIZE_W-1:0] head_size,
	output logic [sfl_pkg::ENTRY_COUNT_W-1:0] entry_count,
	output logic is_empty,
	output logic [sfl_pkg::STAT_W-1:0] status
);
	import sfl_pkg::*;

	cmd_t cmd;
	entry_t head;
	logic [CNT_W-1:0] count;

	// handshake, count bookkeeping and status
	sfl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.count(count),
		.status(status)
	);

	// slot chain, updated in the accept cycle
	sfl_datapath u_datapath (
		.clk(clk),
		.cmd(cmd),
		.entry_offset(entry_offset),
		.entry_size(entry_size),
		.head(head)
	);

	// result fields come straight from the held state
	assign is_empty = (count == '0);
	assign head_offset = is_empty ? '0 : head.offset;
	assign head_size = is_empty ? '0 : head.size;
	assign entry_count = ENTRY_COUNT_W'(count);

endmodule

### verif/size_sorted_free_list_unit_test.sv
// self-checking testbench of the size sorted free list unit
module size_sorted_free_list_unit_test;
	import sfl_pkg::*;

	// kind code the block treats as a no-op
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS_PER_PHASE = 320;

	// what the list shows after one item
	typedef struct {
		logic signed [OFF_W-1:0] head_offset;
		logic signed [SIZE_W-1:0] head_size;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic is_empty;
		logic [STAT_W-1:0] status;
	} list_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = KIND_INSERT;
	logic signed [OFF_W-1:0] entry_offset = '0;
	logic signed [SIZE_W-1:0] entry_size = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OFF_W-1:0] head_offset;
	logic signed [SIZE_W-1:0] head_size;
	logic [ENTRY_COUNT_W-1:0] entry_count;
	logic is_empty;
	logic [STAT_W-1:0] status;

	// shadow copy of the list kept by the predictor
	logic signed [OFF_W-1:0] shadow_offsets [LIST_DEPTH];
	logic signed [SIZE_W-1:0] shadow_sizes [LIST_DEPTH];
	int shadow_count = 0;

	// views still owed by the block, oldest first
	list_view_t pending_views [$];

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off: the test bumps the request, the stall process counts
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_drops = 0;
	int empty_pops = 0;
	int peak_count = 0;

	size_sorted_free_list_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.entry_offset(entry_offset),
		.entry_size(entry_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head_offset(head_offset),
		.head_size(head_size),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// apply one item to the shadow list and return the view it should produce
	function automatic list_view_t apply_to_shadow(input logic [KIND_W-1:0] k,
			input logic signed [OFF_W-1:0] o, input logic signed [SIZE_W-1:0] s);
		list_view_t v;
		int slot;
		v.status = STAT_OK;
		case (k)
			KIND_INSERT, KIND_APPEND: begin
				if (shadow_count >= LIST_DEPTH) begin
					v.status = STAT_FULL;
					full_drops++;
				end else begin
					slot = shadow_count;
					// sorted insert lands ahead of the first entry not larger than it
					if (k == KIND_INSERT)
						for (int i = shadow_count - 1; i >= 0; i--)
							if (shadow_sizes[i] <= s)
								slot = i;
					for (int i = shadow_count; i > slot; i--) begin
						shadow_offsets[i] = shadow_offsets[i - 1];
						shadow_sizes[i] = shadow_sizes[i - 1];
					end
					shadow_offsets[slot] = o;
					shadow_sizes[slot] = s;
					shadow_count++;
				end
			end
			KIND_POP: begin
				if (shadow_count == 0) begin
					v.status = STAT_EMPTY;
					empty_pops++;
				end else begin
					for (int i = 0; i + 1 < shadow_count; i++) begin
						shadow_offsets[i] = shadow_offsets[i + 1];
						shadow_sizes[i] = shadow_sizes[i + 1];
					end
					shadow_count--;
				end
			end
			default: begin
				// unused kind leaves the list alone
			end
		endcase
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		v.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
		v.is_empty = (shadow_count == 0);
		// head reads as zero while empty
		v.head_offset = v.is_empty ? '0 : shadow_offsets[0];
		v.head_size = v.is_empty ? '0 : shadow_sizes[0];
		return v;
	endfunction

	// offer one item, hold it until taken, then record what it should show
	task automatic send_item(input logic [KIND_W-1:0] k, input logic signed [OFF_W-1:0] o,
			input logic signed [SIZE_W-1:0] s);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		entry_offset <= o;
		entry_size <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_views.push_back(apply_to_shadow(k, o, s));
		items_sent++;
	endtask

	// sender goes quiet until every owed result is back
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sizes lean toward a few small values so equal sizes collide often
	function automatic logic signed [SIZE_W-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return -1;
			1, 2, 3, 4: return $urandom_range(0, 15);
			5: return 32'sh7fff_ffff;
			default: return $urandom_range(0, 32'h7fff_ffff);
		endcase
	endfunction

	function automatic logic signed [OFF_W-1:0] random_offset();
		case ($urandom_range(0, 9))
			0: return -1;
			1: return 48'sh7fff_ffff_ffff;
			default: return {1'b0, 15'($urandom_range(0, 16'h7fff)), 32'($urandom)};
		endcase
	endfunction

	// growing bursts favor inserts, shrinking bursts favor pops
	function automatic logic [KIND_W-1:0] random_kind(input bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (r >= 95)
			return KIND_UNUSED;
		if (grow)
			return (r < 55) ? KIND_INSERT : (r < 75) ? KIND_APPEND : KIND_POP;
		return (r < 25) ? KIND_INSERT : (r < 35) ? KIND_APPEND : KIND_POP;
	endfunction

	// each accepted result against the oldest owed view
	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		list_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_views.size() == 0) begin
				$error("result with no item outstanding");
				fail_count++;
			end else begin
				want = pending_views.pop_front();
				check_field("head_offset", 64'(want.head_offset), 64'(head_offset));
				check_field("head_size", 64'(want.head_size), 64'(head_size));
				check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
				check_field("is_empty", 64'(want.is_empty), 64'(is_empty));
				check_field("status", 64'(want.status), 64'(status));
			end
		end
	end

	// receiver stall: random per phase, or a long hold-off when requested
	always @(posedge clk) begin : receiver_stall
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// corners: empty pop, extreme fields, equal sizes, tail append, no-op kind
	task automatic test_directed_corners();
		send_item(KIND_POP, 0, 0);
		send_item(KIND_UNUSED, 0, 0);
		send_item(KIND_INSERT, 0, 100);
		// equal size goes ahead of the older entry
		send_item(KIND_INSERT, -1, 100);
		send_item(KIND_INSERT, 48'sh7fff_ffff_ffff, 32'sh7fff_ffff);
		// sentinel size sorts below zero
		send_item(KIND_INSERT, 5, -1);
		send_item(KIND_INSERT, 6, 0);
		// append ignores order even with the largest size
		send_item(KIND_APPEND, 7, 32'sh7fff_ffff);
		send_item(KIND_APPEND, -1, -1);
		send_item(KIND_UNUSED, -1, -1);
		// walk the list out, two pops past empty
		repeat (8) send_item(KIND_POP, 0, 0);
		send_item(KIND_POP, -1, -1);
		pause_until_drained();
	endtask

	// fill to the brim, knock on a full list, then empty it again
	task automatic test_fill_and_overflow();
		while (shadow_count < LIST_DEPTH)
			send_item($urandom_range(0, 3) == 0 ? KIND_APPEND : KIND_INSERT,
				random_offset(), random_size());
		repeat (3) send_item(KIND_INSERT, random_offset(), random_size());
		repeat (2) send_item(KIND_APPEND, random_offset(), random_size());
		send_item(KIND_UNUSED, random_offset(), random_size());
		send_item(KIND_POP, 0, 0);
		send_item(KIND_INSERT, random_offset(), random_size());
		send_item(KIND_INSERT, random_offset(), random_size());
		while (shadow_count > 0)
			send_item(KIND_POP, random_offset(), random_size());
		repeat (2) send_item(KIND_POP, 0, 0);
		pause_until_drained();
	endtask

	// random bursts that alternately grow and shrink the list
	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int left;
		int burst;
		bit grow;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		left = RANDOM_ITEMS_PER_PHASE;
		grow = 1'b1;
		while (left > 0) begin
			burst = $urandom_range(20, 90);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_item(random_kind(grow), random_offset(), random_size());
				left--;
			end
			grow = !grow;
		end
		pause_until_drained();
	endtask

	// long receiver hold-off with the sender still pushing, so input stalls
	task automatic test_long_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		repeat (40) send_item(random_kind(1'b1), random_offset(), random_size());
		pause_until_drained();
		recv_stall_pct = 26;
		hold_req++;
		repeat (40) send_item(random_kind(1'b0), random_offset(), random_size());
		pause_until_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_fill_and_overflow();
		test_random_phase(0, 0);
		test_random_phase(57, 0);
		test_random_phase(0, 57);
		test_random_phase(26, 26);
		test_long_hold_off();
		$display("sent %0d items, checked %0d results, peak count %0d", items_sent,
			results_seen, peak_count);
		$display("full drops %0d, pops on empty %0d, under four idle mixes and long hold-offs",
			full_drops, empty_pops);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit far above the slowest correct run
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/sfl_pkg.sv
hw/rtl/sfl_ctrl.sv
hw/rtl/sfl_datapath.sv
hw/rtl/size_sorted_free_list_unit.sv
verif/size_sorted_free_list_unit_test.sv
